// File: rtl/wrp_pkg.sv
// wrp_pkg: shared types, codes and constants of the waveform raster plotter
// used by the divider and the top level
`default_nettype none

package wrp_pkg;

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_DRAW  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_OOB  = 2'd2;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd256;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd256;

    localparam logic [7:0] PIX_WHITE = 8'hFF;
    localparam logic [7:0] PIX_BLACK = 8'h00;

    // divider width and the vertical scaling constants
    // row = floor((prod + 32767) / 65534), done as a halving and a divide by 2^15 - 1
    localparam int DIV_W = 32;
    localparam logic [15:0] SAMPLE_MID = 16'h7FFF;
    localparam logic [15:0] Y_BIAS     = 16'd32767;
    localparam logic [15:0] Y_HALF_DEN = 16'd32767;

    // square half-size width
    localparam int HALF_W = 6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic signed [15:0] sample;
        logic [15:0] pixel_address;
    } req_beat_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [1:0] status;
    } rsp_beat_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_D_START,
        S_D_WAIT,
        S_SAMP_RD,
        S_X_START,
        S_X_WAIT,
        S_Y_CALC,
        S_CLIP,
        S_BASE,
        S_PAINT,
        S_READ,
        S_DONE
    } wrp_state_t;

endpackage

`default_nettype wire

// File: rtl/wrp_stream_if.sv
// wrp_stream_if: valid/ready channel carrying one payload beat
// payload type is given by the type parameter T
`default_nettype none

interface wrp_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/wrp_ram.sv
// wrp_ram: single-port-write, single-port-read synchronous ram
// registered read, no dependencies
`default_nettype none

module wrp_ram #(
    parameter int DW    = 1,
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/wrp_div.sv
// wrp_div: restoring divider, one quotient bit per cycle
// depends on wrp_pkg for the request struct and width
`default_nettype none

module wrp_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire wrp_pkg::div_req_t        div_req,
    output logic                          done,
    output logic [wrp_pkg::DIV_W-1:0]     quo
);

    localparam int W  = wrp_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg;
    logic [W:0]    rem_reg, rem_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    trial, diff;

    // one shift-subtract step
    always_comb
    begin
        trial = {rem_reg[W-1:0], quo_reg[W-1]};
        diff  = trial - {1'b0, den_reg};
        if (!diff[W])
        begin
            rem_next = diff;
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            quo_reg <= div_req.num;
            den_reg <= div_req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: rtl/waveform_raster_plotter.sv
// waveform_raster_plotter: sample store, frame store and plotting sequencer
// depends on wrp_pkg, wrp_stream_if, wrp_ram and wrp_div
//
// Every request gives one response beat, held in one output register until it is taken.
// A load goes straight to its response, and a pixel read makes one frame ram read first.
// Clear and draw first sweep the whole frame ram, one pixel per cycle; the same sweep
// runs once after reset, during which no request is taken (configuration writes are).
// A draw with at least two samples and a nonzero frame then runs the half-size division
// and, for each plotted sample, the 32-bit divider for the column (the row comes from a
// constant divide without the divider), then paints the pixels of its clipped square,
// (2d+1)^2 at most, and ends in the response state. While an earlier response beat
// waits, the sequencer holds in that state.
`default_nettype none

module waveform_raster_plotter #(
    parameter int MAX_SAMPLES = 4096,
    parameter int MAX_PIXELS  = 65536
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    wrp_stream_if.sink                       req,
    wrp_stream_if.source                     rsp,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_idx,
    input  wire logic [wrp_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int SAW    = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int PIX_AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int DW     = wrp_pkg::DIV_W;
    localparam int CW     = wrp_pkg::CFG_W;
    localparam int HW     = wrp_pkg::HALF_W;
    localparam int PA_W   = 2 * CW + 2;

    wrp_pkg::wrp_state_t state_reg, state_next;

    logic [CW-1:0]    width_reg, height_reg;
    logic [CNT_W-1:0] count_reg;
    logic             boot_reg, draw_reg;
    logic [PIX_AW-1:0] clr_reg;
    logic             out_valid_reg;
    wrp_pkg::rsp_beat_t out_reg;
    logic [7:0]       pix_pend_reg;
    logic [1:0]       stat_pend_reg;
    logic             oob_reg;

    logic [SAW-1:0]   i_reg;
    logic [HW-1:0]    d_reg;
    logic [CW-1:0]    x_reg;
    logic [CW-1:0]    y_reg;
    logic [CW+SAW-1:0] xmul_reg;
    logic [CW+15:0]   ymul_reg;
    logic [CW:0]      c0_reg, c1_reg, r0_reg, r1_reg, c_reg, r_reg;
    logic [PA_W-1:0]  base_reg;

    // memory and divider hookup
    logic             smp_we, smp_re;
    logic [15:0]      smp_rdata;
    logic             frm_we, frm_re, frm_wdata;
    logic [PIX_AW-1:0] frm_waddr;
    logic             frm_rdata;
    wrp_pkg::div_req_t div_req;
    logic             div_done;
    logic [DW-1:0]    div_quo;

    logic             accept, out_free, clr_last, plot_ok;
    logic             col_last, row_last, samp_last;
    logic [PA_W-1:0]  paddr;
    logic [2*CW-1:0]  area;
    logic             rd_oob;
    logic [DW-1:0]    d_trial;
    logic [15:0]      y_diff;
    logic [CW+16:0]   y_num;
    logic [CW+15:0]   y_half;
    logic [CW:0]      y_q0;
    logic [15:0]      y_rem;
    logic [CW-1:0]    y_val;
    logic [CW:0]      xd_sum, yd_sum;

    wrp_ram #(.DW(16), .DEPTH(MAX_SAMPLES), .AW(SAW)) u_samples (
        .clk   (clk),
        .we    (smp_we),
        .waddr (count_reg[SAW-1:0]),
        .wdata (req.data.sample),
        .re    (smp_re),
        .raddr (i_reg),
        .rdata (smp_rdata)
    );

    wrp_ram #(.DW(1), .DEPTH(MAX_PIXELS), .AW(PIX_AW)) u_frame (
        .clk   (clk),
        .we    (frm_we),
        .waddr (frm_waddr),
        .wdata (frm_wdata),
        .re    (frm_re),
        .raddr (PIX_AW'(req.data.pixel_address)),
        .rdata (frm_rdata)
    );

    wrp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    // shared conditions
    always_comb
    begin
        accept    = req.valid && req.ready;
        out_free  = !out_valid_reg || rsp.ready;
        clr_last  = (clr_reg == PIX_AW'(MAX_PIXELS - 1));
        plot_ok   = (width_reg != '0) && (height_reg != '0) && (count_reg >= CNT_W'(2));
        col_last  = (c_reg == c1_reg);
        row_last  = (r_reg == r1_reg);
        samp_last = (CNT_W'(i_reg) == count_reg - CNT_W'(2));
        paddr     = base_reg + PA_W'(c_reg);
        area      = width_reg * height_reg;
        rd_oob    = (32'(req.data.pixel_address) >= 32'(area))
                    || (32'(req.data.pixel_address) >= 32'(MAX_PIXELS));
        d_trial   = (div_quo < DW'(2)) ? DW'(2) : div_quo;
        // row: halve, then divide by 2^15 - 1 with one correction step
        y_diff    = wrp_pkg::SAMPLE_MID - smp_rdata;
        y_num     = (CW + 17)'(ymul_reg) + (CW + 17)'(wrp_pkg::Y_BIAS);
        y_half    = y_num[CW+16:1];
        y_q0      = y_half[CW+15:15];
        y_rem     = {1'b0, y_half[14:0]} + 16'(y_q0);
        y_val     = CW'(y_q0 + (CW + 1)'(y_rem >= wrp_pkg::Y_HALF_DEN));
        xd_sum    = {1'b0, x_reg} + (CW + 1)'(d_reg);
        yd_sum    = {1'b0, y_reg} + (CW + 1)'(d_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.data.req_type)
                        wrp_pkg::REQ_LOAD:  state_next = wrp_pkg::S_DONE;
                        wrp_pkg::REQ_DRAW:  state_next = wrp_pkg::S_CLEAR;
                        wrp_pkg::REQ_READ:  state_next = wrp_pkg::S_READ;
                        wrp_pkg::REQ_CLEAR: state_next = wrp_pkg::S_CLEAR;
                    endcase
                end
            end
            wrp_pkg::S_CLEAR:
            begin
                if (clr_last)
                begin
                    priority if (boot_reg)
                        state_next = wrp_pkg::S_IDLE;
                    else if (draw_reg && plot_ok)
                        state_next = wrp_pkg::S_D_START;
                    else
                        state_next = wrp_pkg::S_DONE;
                end
            end
            wrp_pkg::S_D_START: state_next = wrp_pkg::S_D_WAIT;
            wrp_pkg::S_D_WAIT:
            begin
                if (div_done)
                    state_next = wrp_pkg::S_SAMP_RD;
            end
            wrp_pkg::S_SAMP_RD: state_next = wrp_pkg::S_X_START;
            wrp_pkg::S_X_START: state_next = wrp_pkg::S_X_WAIT;
            wrp_pkg::S_X_WAIT:
            begin
                if (div_done)
                    state_next = wrp_pkg::S_Y_CALC;
            end
            wrp_pkg::S_Y_CALC:  state_next = wrp_pkg::S_CLIP;
            wrp_pkg::S_CLIP:    state_next = wrp_pkg::S_BASE;
            wrp_pkg::S_BASE:    state_next = wrp_pkg::S_PAINT;
            wrp_pkg::S_PAINT:
            begin
                if (col_last && row_last)
                    state_next = samp_last ? wrp_pkg::S_DONE : wrp_pkg::S_SAMP_RD;
            end
            wrp_pkg::S_READ:    state_next = wrp_pkg::S_DONE;
            wrp_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = wrp_pkg::S_IDLE;
            end
            default:            state_next = wrp_pkg::S_IDLE;
        endcase
    end

    // memory, divider and handshake controls
    always_comb
    begin
        req.ready     = (state_reg == wrp_pkg::S_IDLE);
        smp_we        = 1'b0;
        smp_re        = 1'b0;
        frm_we        = 1'b0;
        frm_re        = 1'b0;
        frm_wdata     = 1'b0;
        frm_waddr     = clr_reg;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (state_reg)
            wrp_pkg::S_IDLE:
            begin
                smp_we = accept && (req.data.req_type == wrp_pkg::REQ_LOAD)
                         && (count_reg < CNT_W'(MAX_SAMPLES));
                frm_re = accept && (req.data.req_type == wrp_pkg::REQ_READ);
            end
            wrp_pkg::S_CLEAR:
            begin
                frm_we = 1'b1;
            end
            wrp_pkg::S_D_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = (DW'(width_reg) << 2) + DW'(count_reg);
                div_req.den   = DW'(count_reg) << 1;
            end
            wrp_pkg::S_SAMP_RD:
            begin
                smp_re = 1'b1;
            end
            wrp_pkg::S_X_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = (DW'(xmul_reg) << 1) + DW'(count_reg);
                div_req.den   = DW'(count_reg) << 1;
            end
            wrp_pkg::S_PAINT:
            begin
                frm_we    = (32'(paddr) < 32'(MAX_PIXELS));
                frm_wdata = 1'b1;
                frm_waddr = PIX_AW'(paddr);
            end
            default:
            begin
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrp_pkg::S_CLEAR;
            boot_reg      <= 1'b1;
            draw_reg      <= 1'b0;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= wrp_pkg::WIDTH_RST;
            height_reg    <= wrp_pkg::HEIGHT_RST;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                if (cfg_idx == wrp_pkg::CFG_WIDTH)
                    width_reg <= cfg_wdata;
                else
                    height_reg <= cfg_wdata;
            end

            // frame sweep
            if (state_reg == wrp_pkg::S_CLEAR)
            begin
                clr_reg <= clr_last ? '0 : clr_reg + PIX_AW'(1);
                if (clr_last)
                    boot_reg <= 1'b0;
            end

            // request decode
            if (accept)
            begin
                draw_reg <= (req.data.req_type == wrp_pkg::REQ_DRAW);
                if (smp_we)
                    count_reg <= count_reg + CNT_W'(1);
                else if (req.data.req_type == wrp_pkg::REQ_CLEAR)
                    count_reg <= '0;
            end

            // response beat
            if ((state_reg == wrp_pkg::S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // plotting datapath and pending result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_pend_reg  <= wrp_pkg::PIX_BLACK;
            stat_pend_reg <= ((req.data.req_type == wrp_pkg::REQ_LOAD) && !smp_we)
                             ? wrp_pkg::STAT_FULL : wrp_pkg::STAT_OK;
            oob_reg       <= rd_oob;
        end

        unique case (state_reg)
            wrp_pkg::S_D_WAIT:
            begin
                if (div_done)
                begin
                    i_reg <= '0;
                    if (d_trial > DW'(height_reg >> 4))
                        d_reg <= HW'(((CW + 1)'(height_reg) + (CW + 1)'(8)) >> 4);
                    else
                        d_reg <= HW'(d_trial);
                end
            end
            wrp_pkg::S_SAMP_RD:
            begin
                xmul_reg <= (CW + SAW)'(width_reg - CW'(1)) * (CW + SAW)'(i_reg);
            end
            wrp_pkg::S_X_START:
            begin
                ymul_reg <= (CW + 16)'(height_reg - CW'(1)) * (CW + 16)'(y_diff);
            end
            wrp_pkg::S_X_WAIT:
            begin
                if (div_done)
                    x_reg <= CW'(div_quo);
            end
            wrp_pkg::S_Y_CALC:
            begin
                y_reg <= y_val;
            end
            wrp_pkg::S_CLIP:
            begin
                c0_reg <= (x_reg >= CW'(d_reg)) ? {1'b0, x_reg - CW'(d_reg)} : '0;
                r0_reg <= (y_reg >= CW'(d_reg)) ? {1'b0, y_reg - CW'(d_reg)} : '0;
                c1_reg <= (xd_sum > {1'b0, width_reg - CW'(1)})
                          ? {1'b0, width_reg - CW'(1)} : xd_sum;
                r1_reg <= (yd_sum > {1'b0, height_reg - CW'(1)})
                          ? {1'b0, height_reg - CW'(1)} : yd_sum;
            end
            wrp_pkg::S_BASE:
            begin
                base_reg <= PA_W'(r0_reg) * PA_W'(width_reg);
                r_reg    <= r0_reg;
                c_reg    <= c0_reg;
            end
            wrp_pkg::S_PAINT:
            begin
                if (col_last)
                begin
                    c_reg <= c0_reg;
                    if (row_last)
                        i_reg <= i_reg + SAW'(1);
                    else
                    begin
                        r_reg    <= r_reg + (CW + 1)'(1);
                        base_reg <= base_reg + PA_W'(width_reg);
                    end
                end
                else
                    c_reg <= c_reg + (CW + 1)'(1);
            end
            wrp_pkg::S_READ:
            begin
                if (oob_reg)
                    stat_pend_reg <= wrp_pkg::STAT_OOB;
                else if (frm_rdata)
                    pix_pend_reg <= wrp_pkg::PIX_WHITE;
            end
            wrp_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_reg.pixel_value <= pix_pend_reg;
                    out_reg.status      <= stat_pend_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

`default_nettype wire
